FILE: rtl/rcs_pkg.sv
// ============================================================================
// rcs_pkg: shared types and constants for the ray / cylinder side core
// Item layouts on both channels and the records passed between the stages.
// ============================================================================
package rcs_pkg;

    localparam int           MIN_DIST_W   = 17;
    localparam logic [16:0]  MIN_DIST_RST = 17'd655;
    localparam int           NORM_FRAC    = 14;
    localparam logic [14:0]  NORM_ONE     = 15'd16384;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic               hit;
        logic [30:0]        distance;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic               last;
    } t_hit_out;

    // quadratic terms and discriminant root of one ray
    typedef struct packed {
        logic               vld;
        t_ray_in            ray;
        logic               ok;
        logic [63:0]        a;
        logic signed [64:0] h;
        logic [64:0]        s;
    } t_quad;

    typedef struct packed {
        logic [30:0]        ray_len;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pt;

    // both roots after the range and height tests
    typedef struct packed {
        logic              vld;
        logic [1:0]        hit;
        t_pt [1:0]         pt;
    } t_root;

    // both roots as finished result items
    typedef struct packed {
        logic              vld;
        logic [1:0]        hit;
        t_hit_out [1:0]    rec;
    } t_nres;

endpackage

FILE: rtl/rcs_quad.sv
// ============================================================================
// rcs_quad: quadratic setup, discriminant and its square root
// Products, a/h/c sums, byte-serial 128-bit products for h*h and a*c, then a
// one-bit-per-stage integer square root of the discriminant.
// ============================================================================
module rcs_quad (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_vld,
    input  rcs_pkg::t_ray_in i_ray,
    output rcs_pkg::t_quad   o_quad
);
    import rcs_pkg::*;

    localparam int MulSteps = 8;
    localparam int SqSteps  = 65;

    typedef struct packed {
        logic               vld;
        t_ray_in            ray;
        logic signed [63:0] xx;
        logic signed [63:0] yy;
        logic signed [63:0] dxx;
        logic signed [63:0] dyy;
        logic signed [63:0] xdx;
        logic signed [63:0] ydy;
    } t_prod;

    typedef struct packed {
        logic               vld;
        t_ray_in            ray;
        logic [63:0]        a;
        logic signed [64:0] h;
        logic [63:0]        habs;
        logic [63:0]        cabs;
        logic               cneg;
        logic [127:0]       hh;
        logic [127:0]       ac;
    } t_qmul;

    typedef struct packed {
        logic               vld;
        t_ray_in            ray;
        logic [63:0]        a;
        logic signed [64:0] h;
        logic               ok;
        logic [129:0]       d;
        logic [64:0]        root;
        logic [67:0]        rem;
    } t_qsq;

    t_prod r_prod, n_prod;
    t_qmul r_mul [0:MulSteps];
    t_qmul n_mul_in;
    t_qsq  r_sq [0:SqSteps];
    t_qsq  n_sq_in;

    always_comb begin
        n_prod.vld = i_vld;
        n_prod.ray = i_ray;
        n_prod.xx  = 64'(i_ray.origin_x * i_ray.origin_x);
        n_prod.yy  = 64'(i_ray.origin_y * i_ray.origin_y);
        n_prod.dxx = 64'(i_ray.dir_x * i_ray.dir_x);
        n_prod.dyy = 64'(i_ray.dir_y * i_ray.dir_y);
        n_prod.xdx = 64'(i_ray.origin_x * i_ray.dir_x);
        n_prod.ydy = 64'(i_ray.origin_y * i_ray.dir_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.vld <= 1'b0;
        end else if (i_ce) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        logic signed [64:0] h_v;
        logic signed [64:0] c_v;
        h_v = 65'(r_prod.xdx) + 65'(r_prod.ydy);
        c_v = 65'(r_prod.xx) + 65'(r_prod.yy) - 65'sh1_0000_0000;
        n_mul_in.vld  = r_prod.vld;
        n_mul_in.ray  = r_prod.ray;
        n_mul_in.a    = $unsigned(r_prod.dxx) + $unsigned(r_prod.dyy);
        n_mul_in.h    = h_v;
        n_mul_in.habs = h_v[64] ? 64'(-h_v) : h_v[63:0];
        n_mul_in.cabs = c_v[64] ? 64'(-c_v) : c_v[63:0];
        n_mul_in.cneg = c_v[64];
        n_mul_in.hh   = '0;
        n_mul_in.ac   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul[0].vld <= 1'b0;
        end else if (i_ce) begin
            r_mul[0] <= n_mul_in;
        end
    end

    // one multiplier byte per stage
    for (genvar k = 0; k < MulSteps; k++) begin : g_mul
        t_qmul       n_m;
        logic [71:0] pp_h;
        logic [71:0] pp_c;

        always_comb begin
            pp_h   = 72'(r_mul[k].habs) * 72'(r_mul[k].habs[8*k +: 8]);
            pp_c   = 72'(r_mul[k].a) * 72'(r_mul[k].cabs[8*k +: 8]);
            n_m    = r_mul[k];
            n_m.hh = r_mul[k].hh + (128'(pp_h) << (8*k));
            n_m.ac = r_mul[k].ac + (128'(pp_c) << (8*k));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mul[k+1].vld <= 1'b0;
            end else if (i_ce) begin
                r_mul[k+1] <= n_m;
            end
        end
    end

    always_comb begin
        logic [129:0] d_v;
        d_v = r_mul[MulSteps].cneg ?
              ({2'b00, r_mul[MulSteps].hh} + {2'b00, r_mul[MulSteps].ac}) :
              ({2'b00, r_mul[MulSteps].hh} - {2'b00, r_mul[MulSteps].ac});
        n_sq_in.vld  = r_mul[MulSteps].vld;
        n_sq_in.ray  = r_mul[MulSteps].ray;
        n_sq_in.a    = r_mul[MulSteps].a;
        n_sq_in.h    = r_mul[MulSteps].h;
        // parallel ray or negative discriminant: no root
        n_sq_in.ok   = (r_mul[MulSteps].a != 64'd0) && !d_v[129];
        n_sq_in.d    = d_v;
        n_sq_in.root = '0;
        n_sq_in.rem  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].vld <= 1'b0;
        end else if (i_ce) begin
            r_sq[0] <= n_sq_in;
        end
    end

    // one root bit per stage, two radicand bits in
    for (genvar j = 0; j < SqSteps; j++) begin : g_sq
        t_qsq        n_s;
        logic [67:0] remx;
        logic [67:0] trial;

        always_comb begin
            remx  = {r_sq[j].rem[65:0], r_sq[j].d[2*(SqSteps-1-j) +: 2]};
            trial = {1'b0, r_sq[j].root, 2'b01};
            n_s   = r_sq[j];
            if (remx >= trial) begin
                n_s.rem  = remx - trial;
                n_s.root = {r_sq[j].root[63:0], 1'b1};
            end else begin
                n_s.rem  = remx;
                n_s.root = {r_sq[j].root[63:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[j+1].vld <= 1'b0;
            end else if (i_ce) begin
                r_sq[j+1] <= n_s;
            end
        end
    end

    assign o_quad.vld = r_sq[SqSteps].vld;
    assign o_quad.ray = r_sq[SqSteps].ray;
    assign o_quad.ok  = r_sq[SqSteps].ok;
    assign o_quad.a   = r_sq[SqSteps].a;
    assign o_quad.h   = r_sq[SqSteps].h;
    assign o_quad.s   = r_sq[SqSteps].root;

endmodule

FILE: rtl/rcs_root.sv
// ============================================================================
// rcs_root: both roots, distance test and hit point
// Restoring division of the root numerators by a, one quotient bit a stage,
// then byte-serial d*t products, the height test and saturation.
// ============================================================================
module rcs_root (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  rcs_pkg::t_quad i_quad,
    input  logic [16:0]    i_min_dist,
    output rcs_pkg::t_root o_root
);
    import rcs_pkg::*;

    localparam int DivSteps = 82;
    localparam int MulSteps = 4;

    typedef struct packed {
        logic             vld;
        t_ray_in          ray;
        logic [63:0]      a;
        logic [1:0]       ok;
        logic [1:0][81:0] m;
        logic [1:0][81:0] q;
        logic [1:0][63:0] rem;
    } t_rdiv;

    typedef struct packed {
        logic                   vld;
        t_ray_in                ray;
        logic [1:0]             ok;
        logic [1:0][81:0]       t;
        logic [1:0][2:0][113:0] pr;
    } t_rmul;

    function automatic logic signed [31:0] sat32(input logic signed [100:0] v);
        if (v > 101'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -101'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    t_rdiv r_div [0:DivSteps];
    t_rdiv n_div_in;
    t_rmul r_mul [0:MulSteps];
    t_rmul n_mul_in;
    t_root r_out, n_out;

    always_comb begin
        logic signed [66:0] hx;
        logic signed [66:0] sx;
        logic signed [66:0] nm;
        hx = 67'(i_quad.h);
        sx = signed'(67'(i_quad.s));
        n_div_in.vld = i_quad.vld;
        n_div_in.ray = i_quad.ray;
        n_div_in.a   = i_quad.a;
        n_div_in.q   = '0;
        n_div_in.rem = '0;
        for (int r = 0; r < 2; r++) begin
            nm = (r == 0) ? (-hx - sx) : (-hx + sx);
            // a root at or below zero never passes the distance test
            n_div_in.ok[r] = i_quad.ok && !nm[66] && (nm != 67'sd0);
            n_div_in.m[r]  = {nm[65:0], 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].vld <= 1'b0;
        end else if (i_ce) begin
            r_div[0] <= n_div_in;
        end
    end

    for (genvar i = 0; i < DivSteps; i++) begin : g_div
        t_rdiv       n_d;
        logic [64:0] rx;

        always_comb begin
            n_d = r_div[i];
            rx  = '0;
            for (int r = 0; r < 2; r++) begin
                rx = {r_div[i].rem[r], r_div[i].m[r][DivSteps-1-i]};
                if (rx >= {1'b0, r_div[i].a}) begin
                    n_d.rem[r] = 64'(rx - {1'b0, r_div[i].a});
                    n_d.q[r]   = {r_div[i].q[r][80:0], 1'b1};
                end else begin
                    n_d.rem[r] = rx[63:0];
                    n_d.q[r]   = {r_div[i].q[r][80:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[i+1].vld <= 1'b0;
            end else if (i_ce) begin
                r_div[i+1] <= n_d;
            end
        end
    end

    always_comb begin
        n_mul_in.vld = r_div[DivSteps].vld;
        n_mul_in.ray = r_div[DivSteps].ray;
        n_mul_in.t   = r_div[DivSteps].q;
        n_mul_in.pr  = '0;
        for (int r = 0; r < 2; r++) begin
            n_mul_in.ok[r] = r_div[DivSteps].ok[r] &&
                             (r_div[DivSteps].q[r] > 82'(i_min_dist));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul[0].vld <= 1'b0;
        end else if (i_ce) begin
            r_mul[0] <= n_mul_in;
        end
    end

    // |d| * t, one byte of |d| per stage
    for (genvar k = 0; k < MulSteps; k++) begin : g_mul
        t_rmul            n_m;
        logic [2:0][31:0] dabs;
        logic [89:0]      pp;

        always_comb begin
            dabs[0] = r_mul[k].ray.dir_x[31] ? (~r_mul[k].ray.dir_x + 32'd1)
                                             : r_mul[k].ray.dir_x;
            dabs[1] = r_mul[k].ray.dir_y[31] ? (~r_mul[k].ray.dir_y + 32'd1)
                                             : r_mul[k].ray.dir_y;
            dabs[2] = r_mul[k].ray.dir_z[31] ? (~r_mul[k].ray.dir_z + 32'd1)
                                             : r_mul[k].ray.dir_z;
            n_m = r_mul[k];
            pp  = '0;
            for (int r = 0; r < 2; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pp = 90'(r_mul[k].t[r]) * 90'(dabs[c][8*k +: 8]);
                    n_m.pr[r][c] = r_mul[k].pr[r][c] + (114'(pp) << (8*k));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mul[k+1].vld <= 1'b0;
            end else if (i_ce) begin
                r_mul[k+1] <= n_m;
            end
        end
    end

    always_comb begin
        logic signed [114:0]      sp;
        logic signed [114:0]      sh;
        logic [2:0]               dneg;
        logic [2:0][31:0]         org;
        logic signed [2:0][100:0] pv;
        t_rmul                    p;
        p       = r_mul[MulSteps];
        dneg[0] = p.ray.dir_x[31];
        dneg[1] = p.ray.dir_y[31];
        dneg[2] = p.ray.dir_z[31];
        org[0]  = p.ray.origin_x;
        org[1]  = p.ray.origin_y;
        org[2]  = p.ray.origin_z;
        sp      = '0;
        sh      = '0;
        pv      = '0;
        n_out.vld = p.vld;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 3; c++) begin
                sp = signed'({1'b0, p.pr[r][c]});
                if (dneg[c]) begin
                    sp = -sp;
                end
                // arithmetic shift floors toward minus infinity
                sh    = sp >>> 16;
                pv[c] = 101'(signed'(org[c])) + signed'(sh[100:0]);
            end
            n_out.hit[r] = p.ok[r] && (signed'(pv[2]) >= -101'sd65536) &&
                           (signed'(pv[2]) <= 101'sd65536);
            n_out.pt[r].ray_len = (|p.t[r][81:31]) ? 31'h7fff_ffff : p.t[r][30:0];
            n_out.pt[r].x       = sat32(pv[0]);
            n_out.pt[r].y       = sat32(pv[1]);
            n_out.pt[r].z       = sat32(pv[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_root = r_out;

endmodule

FILE: rtl/rcs_norm.sv
// ============================================================================
// rcs_norm: radial normal of both hit points
// Radius by bit-serial square root of x*x + y*y, then x and y scaled to Q1.14
// by a restoring division, one quotient bit a stage.
// ============================================================================
module rcs_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  rcs_pkg::t_root i_root,
    output rcs_pkg::t_nres o_nres
);
    import rcs_pkg::*;

    localparam int SqSteps  = 32;
    localparam int DivSteps = NORM_FRAC + 1;

    typedef struct packed {
        logic             vld;
        logic [1:0]       hit;
        t_pt [1:0]        pt;
        logic [1:0][63:0] xx;
        logic [1:0][63:0] yy;
    } t_nsqr;

    typedef struct packed {
        logic             vld;
        logic [1:0]       hit;
        t_pt [1:0]        pt;
        logic [1:0][63:0] v;
        logic [1:0][31:0] root;
        logic [1:0][33:0] rem;
    } t_nrt;

    typedef struct packed {
        logic                  vld;
        logic [1:0]            hit;
        t_pt [1:0]             pt;
        logic [1:0][31:0]      rad;
        logic [1:0][1:0][31:0] ax;
        logic [1:0][1:0][31:0] rem;
        logic [1:0][1:0][14:0] q;
    } t_ndiv;

    t_nsqr r_sqr, n_sqr;
    t_nrt  r_rt [0:SqSteps];
    t_nrt  n_rt_in;
    t_ndiv r_dv [0:DivSteps];
    t_ndiv n_dv_in;
    t_nres r_out, n_out;

    always_comb begin
        n_sqr.vld = i_root.vld;
        n_sqr.hit = i_root.hit;
        n_sqr.pt  = i_root.pt;
        for (int r = 0; r < 2; r++) begin
            n_sqr.xx[r] = 64'(i_root.pt[r].x * i_root.pt[r].x);
            n_sqr.yy[r] = 64'(i_root.pt[r].y * i_root.pt[r].y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqr.vld <= 1'b0;
        end else if (i_ce) begin
            r_sqr <= n_sqr;
        end
    end

    always_comb begin
        n_rt_in.vld  = r_sqr.vld;
        n_rt_in.hit  = r_sqr.hit;
        n_rt_in.pt   = r_sqr.pt;
        n_rt_in.root = '0;
        n_rt_in.rem  = '0;
        for (int r = 0; r < 2; r++) begin
            n_rt_in.v[r] = r_sqr.xx[r] + r_sqr.yy[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt[0].vld <= 1'b0;
        end else if (i_ce) begin
            r_rt[0] <= n_rt_in;
        end
    end

    for (genvar j = 0; j < SqSteps; j++) begin : g_sq
        t_nrt        n_s;
        logic [35:0] remx;
        logic [35:0] trial;

        always_comb begin
            n_s   = r_rt[j];
            remx  = '0;
            trial = '0;
            for (int r = 0; r < 2; r++) begin
                remx  = {r_rt[j].rem[r], r_rt[j].v[r][2*(SqSteps-1-j) +: 2]};
                trial = {2'b00, r_rt[j].root[r], 2'b01};
                if (remx >= trial) begin
                    n_s.rem[r]  = 34'(remx - trial);
                    n_s.root[r] = {r_rt[j].root[r][30:0], 1'b1};
                end else begin
                    n_s.rem[r]  = remx[33:0];
                    n_s.root[r] = {r_rt[j].root[r][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt[j+1].vld <= 1'b0;
            end else if (i_ce) begin
                r_rt[j+1] <= n_s;
            end
        end
    end

    always_comb begin
        logic [31:0] a_v;
        n_dv_in.vld = r_rt[SqSteps].vld;
        n_dv_in.hit = r_rt[SqSteps].hit;
        n_dv_in.pt  = r_rt[SqSteps].pt;
        n_dv_in.rad = r_rt[SqSteps].root;
        n_dv_in.q   = '0;
        a_v         = '0;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                a_v = (c == 0) ? r_rt[SqSteps].pt[r].x : r_rt[SqSteps].pt[r].y;
                if (a_v[31]) begin
                    a_v = ~a_v + 32'd1;
                end
                n_dv_in.ax[r][c]  = a_v;
                // upper bits of |v| << 14 already lie below the radius
                n_dv_in.rem[r][c] = {1'b0, a_v[31:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (i_ce) begin
            r_dv[0] <= n_dv_in;
        end
    end

    for (genvar i = 0; i < DivSteps; i++) begin : g_div
        t_ndiv       n_d;
        logic [32:0] rx;
        logic        nb;

        always_comb begin
            n_d = r_dv[i];
            rx  = '0;
            nb  = 1'b0;
            for (int r = 0; r < 2; r++) begin
                for (int c = 0; c < 2; c++) begin
                    nb = (i == 0) ? r_dv[i].ax[r][c][0] : 1'b0;
                    rx = {r_dv[i].rem[r][c], nb};
                    if (rx >= {1'b0, r_dv[i].rad[r]}) begin
                        n_d.rem[r][c] = 32'(rx - {1'b0, r_dv[i].rad[r]});
                        n_d.q[r][c]   = {r_dv[i].q[r][c][13:0], 1'b1};
                    end else begin
                        n_d.rem[r][c] = rx[31:0];
                        n_d.q[r][c]   = {r_dv[i].q[r][c][13:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i+1].vld <= 1'b0;
            end else if (i_ce) begin
                r_dv[i+1] <= n_d;
            end
        end
    end

    always_comb begin
        logic [1:0][15:0] nv;
        logic [14:0]      qc;
        t_ndiv            p;
        p         = r_dv[DivSteps];
        nv        = '0;
        qc        = '0;
        n_out.vld = p.vld;
        n_out.hit = p.hit;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                qc = (p.q[r][c] > NORM_ONE) ? NORM_ONE : p.q[r][c];
                nv[c] = ((c == 0) ? p.pt[r].x[31] : p.pt[r].y[31]) ?
                        (16'd0 - {1'b0, qc}) : {1'b0, qc};
                // zero radius: no direction, drop the normal
                if (p.rad[r] == 32'd0) begin
                    nv[c] = '0;
                end
            end
            n_out.rec[r].hit      = 1'b1;
            n_out.rec[r].distance = p.pt[r].ray_len;
            n_out.rec[r].hit_x    = p.pt[r].x;
            n_out.rec[r].hit_y    = p.pt[r].y;
            n_out.rec[r].hit_z    = p.pt[r].z;
            n_out.rec[r].normal_x = nv[0];
            n_out.rec[r].normal_y = nv[1];
            n_out.rec[r].last     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_nres = r_out;

endmodule

FILE: rtl/ray_cylinder_side_intersect_core.sv
// ============================================================================
// ray_cylinder_side_intersect_core: ray against the side of the unit cylinder
// Top level: min_distance register, pipeline and result sequencing.
// ============================================================================
// A fixed pipeline of 216 register stages from ray to first result. A ray is
// taken every cycle while results drain; a ray with two side hits gives two
// result items and stalls the whole pipeline until the second is taken.
// Rays with no hit or one hit give one result item; a no-hit item has hit=0,
// last=1, others zero. Stall from the result side freezes every stage.
// min_distance may be written only while no ray is in flight.
module ray_cylinder_side_intersect_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ray_valid,
    output logic              o_ray_ready,
    input  rcs_pkg::t_ray_in  i_ray,
    output logic              o_hit_valid,
    input  logic              i_hit_ready,
    output rcs_pkg::t_hit_out o_hit,
    input  logic              i_cfg_wr_en,
    input  logic [16:0]       i_cfg_wr_data
);
    import rcs_pkg::*;

    logic [MIN_DIST_W-1:0] r_min_dist;
    logic                  r_phase;
    logic                  ce;
    logic                  fire;
    logic                  fire_last;
    t_quad                 quad;
    t_root                 root;
    t_nres                 nres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= MIN_DIST_RST;
        end else if (i_cfg_wr_en) begin
            r_min_dist <= i_cfg_wr_data;
        end
    end

    rcs_quad u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (i_ray_valid),
        .i_ray   (i_ray),
        .o_quad  (quad)
    );

    rcs_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_quad     (quad),
        .i_min_dist (r_min_dist),
        .o_root     (root)
    );

    rcs_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_root  (root),
        .o_nres  (nres)
    );

    // near root first, far root second
    always_comb begin
        o_hit = '0;
        if (nres.hit == 2'b00) begin
            o_hit.last = 1'b1;
        end else begin
            o_hit      = (r_phase || !nres.hit[0]) ? nres.rec[1] : nres.rec[0];
            o_hit.last = !(nres.hit[0] && nres.hit[1] && !r_phase);
        end
    end

    assign o_hit_valid = nres.vld;
    assign fire        = o_hit_valid && i_hit_ready;
    assign fire_last   = fire && o_hit.last;
    assign ce          = !nres.vld || fire_last;
    assign o_ray_ready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (fire_last) begin
            r_phase <= 1'b0;
        end else if (fire) begin
            r_phase <= 1'b1;
        end
    end

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid && i_hit_ready && !o_hit.last |=> o_hit_valid && o_hit.last)
        else $error("second result of a ray missing");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid && !o_hit.hit |-> o_hit.last && (o_hit.distance == 31'd0))
        else $error("no-hit item malformed");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid && o_hit.hit |-> (o_hit.normal_x <= 16'sd16384) &&
        (o_hit.normal_x >= -16'sd16384) && (o_hit.normal_y <= 16'sd16384) &&
        (o_hit.normal_y >= -16'sd16384))
        else $error("normal out of range");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hit_valid && !r_phase)
        else $error("output not cleared by reset");

endmodule
